// ===== rtl/core/jets_pkg.sv =====
// Shared types, constants and helper functions for the Julia escape-time pixel block.
package jets_pkg;

	localparam int FRAC_BITS = 13;
	localparam int MAX_ITER  = 300;
	localparam int ZW        = FRAC_BITS + 4;      // |z| < 8 while iterating
	localparam int PW        = 2 * ZW;             // width of a square or cross product
	localparam int NUM_W     = FRAC_BITS + 24;     // |3*off| < 2^12, shifted by F+12
	localparam int DVS_W     = 27;                 // zoom (16) x size (11)
	localparam int REM_W     = DVS_W + 1;
	localparam int STEP_W    = $clog2(NUM_W + 1);
	localparam int CNT_W     = 9;

	localparam logic [2:0] REG_C_REAL = 3'd0;
	localparam logic [2:0] REG_C_IMAG = 3'd1;
	localparam logic [2:0] REG_ZOOM   = 3'd2;
	localparam logic [2:0] REG_WIDTH  = 3'd3;
	localparam logic [2:0] REG_HEIGHT = 3'd4;

	typedef logic signed [ZW-1:0] coord_t;

	typedef struct packed {
		logic signed [15:0] c_real;
		logic signed [15:0] c_imag;
		logic [15:0]        zoom;
		logic [10:0]        width;
		logic [10:0]        height;
	} cfg_t;

	typedef struct packed {
		logic [9:0] px;
		logic [9:0] py;
		coord_t     re;
		coord_t     im;
	} job_t;

	localparam coord_t COORD_MAX = {2'b00, {(ZW-2){1'b1}}};
	localparam coord_t COORD_MIN = {2'b11, {(ZW-2){1'b0}}};

	// Q3.13 constant to FRAC_BITS, truncated toward zero
	function automatic coord_t scale_c(input logic signed [15:0] c);
		logic signed [47:0] w;
		logic signed [47:0] m;
		w = 48'(c);
		if (FRAC_BITS >= 13) begin
			w = w <<< ((FRAC_BITS >= 13) ? (FRAC_BITS - 13) : 0);
		end else begin
			m = (w < 0) ? -w : w;
			m = m >>> ((FRAC_BITS < 13) ? (13 - FRAC_BITS) : 0);
			w = (c < 0) ? -m : m;
		end
		return w[ZW-1:0];
	endfunction

	// 255 - floor(d*255/100) for d in 0..100, divide done by reciprocal
	function automatic logic [7:0] ramp(input logic [6:0] d);
		logic [14:0] x;
		logic [27:0] p;
		x = 15'(d) * 15'd255;
		p = 28'(x) * 28'd5243;
		return 8'd255 - p[26:19];
	endfunction

	function automatic logic [15:0] color565(input logic [CNT_W-1:0] n);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		if (n < 9'd100) begin
			r = 8'd255; g = 8'd255; b = ramp(n[6:0]);
		end else if (n < 9'd200) begin
			r = 8'd255; g = ramp(7'(n - 9'd100)); b = 8'd0;
		end else begin
			r = ramp(7'(n - 9'd200)); g = 8'd0; b = 8'd0;
		end
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

// ===== rtl/core/jets_ifs.sv =====
// Valid/ready channel interfaces for pixel words and result words.
interface jets_pix_if;
	logic       valid;
	logic       ready;
	logic [9:0] pixel_x;
	logic [9:0] pixel_y;
	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface jets_res_if;
	logic        valid;
	logic        ready;
	logic [9:0]  out_x;
	logic [9:0]  out_y;
	logic [9:0]  mirror_x;
	logic [9:0]  mirror_y;
	logic [8:0]  iterations;
	logic [15:0] color;
	modport source (output valid, out_x, out_y, mirror_x, mirror_y, iterations, color,
		input ready);
	modport sink (input valid, out_x, out_y, mirror_x, mirror_y, iterations, color,
		output ready);
endinterface

// ===== rtl/core/jets_front.sv =====
// Front end: takes a pixel word and maps it to a start point with a serial divider.
module jets_front (
	input  logic              clk,
	input  logic              arst_n,
	input  jets_pkg::cfg_t    cfg,
	jets_pix_if.sink          pix,
	output jets_pkg::job_t    job,
	output logic              job_valid,
	input  logic              job_ready
);

	typedef enum logic [1:0] {F_IDLE, F_SETUP, F_DIV, F_PUSH} fstate_t;

	fstate_t                            state_q;
	logic                               sel_q;     // 0: column, 1: row
	logic [9:0]                         px_q;
	logic [9:0]                         py_q;
	jets_pkg::coord_t                   re_q;
	jets_pkg::coord_t                   im_q;
	logic [jets_pkg::DVS_W-1:0]         dvs_q;
	logic [jets_pkg::REM_W-1:0]         rem_q;
	logic [jets_pkg::NUM_W-1:0]         quo_q;
	logic                               neg_q;
	logic [jets_pkg::STEP_W-1:0]        step_q;

	logic [9:0]                         p;
	logic [10:0]                        size;
	logic [15:0]                        zeff;
	logic [10:0]                        seff;
	logic signed [13:0]                 off;
	logic signed [13:0]                 prod;
	logic [13:0]                        pmag;
	logic [jets_pkg::REM_W-1:0]         rem_sh;
	logic                               ge;
	logic [jets_pkg::REM_W-1:0]         rem_n;
	logic [jets_pkg::NUM_W-1:0]         quo_n;
	logic                               big;
	jets_pkg::coord_t                   qz;
	jets_pkg::coord_t                   coord;

	always_comb begin
		p    = sel_q ? py_q : px_q;
		size = sel_q ? cfg.height : cfg.width;
		zeff = (cfg.zoom == 16'd0) ? 16'd1 : cfg.zoom;
		seff = (size == 11'd0) ? 11'd1 : size;
		off  = signed'({4'b0, p}) - signed'({4'b0, size[10:1]});
		prod = sel_q ? (off <<< 1) : ((off <<< 1) + off);
		pmag = prod[13] ? 14'(-prod) : 14'(prod);

		rem_sh = {rem_q[jets_pkg::REM_W-2:0], quo_q[jets_pkg::NUM_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_n  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		quo_n  = {quo_q[jets_pkg::NUM_W-2:0], ge};

		// quotient at or above 4.0 saturates
		big   = |quo_n[jets_pkg::NUM_W-1:jets_pkg::FRAC_BITS+2];
		qz    = {1'b0, quo_n[jets_pkg::FRAC_BITS+2:0]};
		if (neg_q) begin
			coord = big ? jets_pkg::COORD_MIN : -qz;
		end else begin
			coord = big ? jets_pkg::COORD_MAX : qz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			sel_q   <= 1'b0;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (pix.valid) begin
						px_q    <= pix.pixel_x;
						py_q    <= pix.pixel_y;
						sel_q   <= 1'b0;
						state_q <= F_SETUP;
					end
				end
				F_SETUP: begin
					dvs_q   <= 27'(zeff * seff);
					rem_q   <= '0;
					quo_q   <= {pmag[11:0], {(jets_pkg::NUM_W-12){1'b0}}};
					neg_q   <= prod[13];
					step_q  <= '0;
					state_q <= F_DIV;
				end
				F_DIV: begin
					rem_q  <= rem_n;
					quo_q  <= quo_n;
					step_q <= step_q + 1'b1;
					if (step_q == jets_pkg::STEP_W'(jets_pkg::NUM_W - 1)) begin
						if (!sel_q) begin
							re_q    <= coord;
							sel_q   <= 1'b1;
							state_q <= F_SETUP;
						end else begin
							im_q    <= coord;
							state_q <= F_PUSH;
						end
					end
				end
				F_PUSH: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign pix.ready = (state_q == F_IDLE);
	assign job_valid = (state_q == F_PUSH);
	assign job       = '{px: px_q, py: py_q, re: re_q, im: im_q};

endmodule

// ===== rtl/core/jets_fifo.sv =====
// Two-entry queue that decouples the start-point front end from the iterator.
module jets_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  jets_pkg::job_t in_job,
	input  logic           in_valid,
	output logic           in_ready,
	output jets_pkg::job_t out_job,
	output logic           out_valid,
	input  logic           out_ready
);

	jets_pkg::job_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/core/jets_back.sv =====
// Back end: iterates z = z*z + c, then builds the result word with mirror and colour.
module jets_back (
	input  logic           clk,
	input  logic           arst_n,
	input  jets_pkg::cfg_t cfg,
	input  jets_pkg::job_t job,
	input  logic           job_valid,
	output logic           job_ready,
	jets_res_if.source     res
);

	typedef enum logic [1:0] {B_IDLE, B_MUL, B_UPD, B_OUT} bstate_t;

	localparam logic [jets_pkg::PW:0] BOUND = (jets_pkg::PW+1)'(4) << (2*jets_pkg::FRAC_BITS);

	bstate_t                         state_q;
	logic [9:0]                      px_q;
	logic [9:0]                      py_q;
	jets_pkg::coord_t                re_q;
	jets_pkg::coord_t                im_q;
	logic [jets_pkg::CNT_W-1:0]      n_q;
	logic signed [jets_pkg::PW-1:0]  rr_q;
	logic signed [jets_pkg::PW-1:0]  ii_q;
	logic signed [jets_pkg::PW-1:0]  ri_q;

	logic [jets_pkg::PW:0]           mag2;
	logic signed [jets_pkg::PW-1:0]  diff;
	logic signed [jets_pkg::PW-1:0]  dsh;
	logic signed [jets_pkg::PW-1:0]  xsh;
	jets_pkg::coord_t                nr;
	jets_pkg::coord_t                ni;
	logic [jets_pkg::CNT_W-1:0]      n_inc;
	logic [10:0]                     mx;
	logic [10:0]                     my;

	always_comb begin
		mag2  = {1'b0, rr_q} + {1'b0, ii_q};
		diff  = rr_q - ii_q;
		dsh   = diff >>> jets_pkg::FRAC_BITS;
		xsh   = ri_q >>> (jets_pkg::FRAC_BITS - 1);
		nr    = dsh[jets_pkg::ZW-1:0] + jets_pkg::scale_c(cfg.c_real);
		ni    = xsh[jets_pkg::ZW-1:0] + jets_pkg::scale_c(cfg.c_imag);
		n_inc = n_q + 1'b1;
		mx    = cfg.width - {1'b0, px_q} - 11'd1;
		my    = cfg.height - {1'b0, py_q} - 11'd1;
	end

	assign job_ready = (state_q == B_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			res.valid <= 1'b0;
		end else begin
			// in B_OUT the load below owns the valid flag
			if (res.valid && res.ready && state_q != B_OUT) begin
				res.valid <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						px_q    <= job.px;
						py_q    <= job.py;
						re_q    <= job.re;
						im_q    <= job.im;
						n_q     <= '0;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					rr_q    <= re_q * re_q;
					ii_q    <= im_q * im_q;
					ri_q    <= re_q * im_q;
					state_q <= B_UPD;
				end
				B_UPD: begin
					if (mag2 >= BOUND) begin
						state_q <= B_OUT;
					end else begin
						re_q <= nr;
						im_q <= ni;
						n_q  <= n_inc;
						if (n_inc == jets_pkg::CNT_W'(jets_pkg::MAX_ITER)) begin
							state_q <= B_OUT;
						end else begin
							state_q <= B_MUL;
						end
					end
				end
				B_OUT: begin
					// output register free or draining this cycle
					if (!res.valid || res.ready) begin
						res.valid      <= 1'b1;
						res.out_x      <= px_q;
						res.out_y      <= py_q;
						res.mirror_x   <= mx[9:0];
						res.mirror_y   <= my[9:0];
						res.iterations <= n_q;
						res.color      <= jets_pkg::color565(n_q);
						state_q        <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/julia_escape_time_pixel.sv =====
// Julia escape-time pixel. A pixel word is taken on pix when the front end is free; the
// front end derives the start point with a one-bit-per-cycle divider, a setup and a
// division per coordinate plus a hand-off, and passes it through a two-word queue to the
// iterator. The iterator shares one set of multipliers; each iteration has the products
// registered, then the escape test and update. A pixel leaves the iterator when it escapes
// or reaches the 300 cap, and the front end works on the next pixel meanwhile. The result
// word sits in an output register until taken.
// Registers are written over APB at 4*index: c_real, c_imag, zoom_factor, then the
// screen width and height; write them only while idle.
module julia_escape_time_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	jets_pix_if.sink    pix,
	jets_res_if.source  res
);

	jets_pkg::cfg_t cfg_q;
	jets_pkg::job_t f_job;
	logic           f_valid;
	logic           f_ready;
	jets_pkg::job_t b_job;
	logic           b_valid;
	logic           b_ready;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real <= 16'sd0;
			cfg_q.c_imag <= 16'sd0;
			cfg_q.zoom   <= 16'd2048;
			cfg_q.width  <= 11'd320;
			cfg_q.height <= 11'd240;
		end else if (wr_en) begin
			case (paddr[4:2])
				jets_pkg::REG_C_REAL: cfg_q.c_real <= pwdata[15:0];
				jets_pkg::REG_C_IMAG: cfg_q.c_imag <= pwdata[15:0];
				jets_pkg::REG_ZOOM:   cfg_q.zoom   <= pwdata[15:0];
				jets_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[10:0];
				jets_pkg::REG_HEIGHT: cfg_q.height <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			jets_pkg::REG_C_REAL: prdata = {16'd0, cfg_q.c_real};
			jets_pkg::REG_C_IMAG: prdata = {16'd0, cfg_q.c_imag};
			jets_pkg::REG_ZOOM:   prdata = {16'd0, cfg_q.zoom};
			jets_pkg::REG_WIDTH:  prdata = {21'd0, cfg_q.width};
			jets_pkg::REG_HEIGHT: prdata = {21'd0, cfg_q.height};
			default:              prdata = 32'd0;
		endcase
	end

	jets_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix       (pix),
		.job       (f_job),
		.job_valid (f_valid),
		.job_ready (f_ready)
	);

	jets_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_job    (f_job),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.out_job   (b_job),
		.out_valid (b_valid),
		.out_ready (b_ready)
	);

	jets_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (b_job),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.res       (res)
	);

endmodule

// ===== rtl/core/jets_chk.sv =====
// Port-level checks on the result channel, bound to the top level.
module jets_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [8:0]  iterations,
	input logic [15:0] color
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> iterations <= 9'd300)
		else $error("iteration count above cap");

	a_low_band: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && iterations < 9'd100 |-> color[15:5] == 11'h7FF)
		else $error("low band must be full red and green");

	a_high_band: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && iterations >= 9'd200 |-> color[10:0] == 11'd0)
		else $error("high band must have no green or blue");

endmodule

bind julia_escape_time_pixel jets_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.iterations (res.iterations),
	.color      (res.color)
);
